@@ sv/sdsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsa_pkg
// Field widths, request codes and register indexes shared by the diagonal
// scatter-add block.
// ----------------------------------------------------------------------------
package sdsa_pkg;

   localparam int ACTION_W    = 2;
   localparam int AXIS_W      = 2;
   localparam int SLOT_W      = 3;
   localparam int WEIGHT_W    = 32;
   localparam int FRAC_W      = 24;
   localparam int DOF_W       = 12;
   localparam int ENTRY_W     = 48;
   localparam int PPA_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int MIN_POINTS  = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_WEIGHT = 2'd0,
      ACT_WRITE_ENTRY = 2'd1,
      ACT_ACCUMULATE  = 2'd2,
      ACT_READ_ENTRY  = 2'd3
   } action_type;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POINTS_PER_AXIS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_MODE     = 2'd1;

   localparam logic [PPA_W-1:0] PPA_RESET = 4'd4;

endpackage
`default_nettype wire

@@ sv/sem_mass_diagonal_scatter_add_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: load weight and write entry finish on acceptance; a read captures the
// entry, then loads the response register once it is free; accumulate runs ST_MUL_CJ,
// ST_MUL_X, ST_MUL_Y, ST_MUL_Z, then ST_RMW_RD and ST_RMW_WR per index (one scalar, three vector).
// Throughput: one request at a time; the sequencer holds req_stall until it is done.
// Reset: synchronous; a clearing pass then zeroes every entry of the diagonal RAM,
// during which no request is accepted (csr writes are taken).
// ----------------------------------------------------------------------------
// sem_mass_diagonal_scatter_add_core
// Lumped mass diagonal assembly: weight tables, point counters, one shared
// Q8.24 multiplier and a read-modify-write sequencer on the diagonal store.
// ----------------------------------------------------------------------------
module sem_mass_diagonal_scatter_add_core #(
   parameter int DIAG_DEPTH = 4096,
   parameter int MAX_POINTS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic        [sdsa_pkg::ACTION_W-1:0]  req_action,
   input  wire logic        [sdsa_pkg::AXIS_W-1:0]    req_axis,
   input  wire logic        [sdsa_pkg::SLOT_W-1:0]    req_point_slot,
   input  wire logic signed [sdsa_pkg::WEIGHT_W-1:0]  req_weight_value,
   input  wire logic signed [sdsa_pkg::WEIGHT_W-1:0]  req_coefficient,
   input  wire logic signed [sdsa_pkg::WEIGHT_W-1:0]  req_jacobian_det,
   input  wire logic        [sdsa_pkg::DOF_W-1:0]     req_dof_first,
   input  wire logic        [sdsa_pkg::DOF_W-1:0]     req_dof_second,
   input  wire logic        [sdsa_pkg::DOF_W-1:0]     req_dof_third,
   input  wire logic signed [sdsa_pkg::ENTRY_W-1:0]   req_entry_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed      [sdsa_pkg::ENTRY_W-1:0]   rsp_read_value,
   output logic             [sdsa_pkg::DOF_W-1:0]     rsp_read_address,
   input  wire logic                                  csr_we,
   input  wire logic        [sdsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [sdsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import sdsa_pkg::*;

   localparam int DAW   = $clog2(DIAG_DEPTH);
   localparam int CMP_W = ((DAW > DOF_W) ? DAW : DOF_W) + 1;
   localparam int PW    = $clog2(MAX_POINTS);
   localparam int NW    = $clog2(MAX_POINTS + 1);
   localparam int CW    = (NW > PPA_W) ? NW : PPA_W;
   localparam int SCW   = (CW > SLOT_W) ? CW : SLOT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_CJ,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_READ_RSP
   } state_type;

   state_type                state_ff, state_in;
   logic                     clr_ff, clr_in;
   logic [DAW-1:0]           clr_addr_ff, clr_addr_in;
   logic [PPA_W-1:0]         ppa_ff, ppa_in;
   logic                     vec_ff, vec_in;
   logic [PW-1:0]            pos_x_ff, pos_x_in;
   logic [PW-1:0]            pos_y_ff, pos_y_in;
   logic [PW-1:0]            pos_z_ff, pos_z_in;
   logic [1:0]               k_ff, k_in;
   logic signed [WEIGHT_W-1:0] coef_ff, coef_in;
   logic signed [WEIGHT_W-1:0] jac_ff, jac_in;
   logic signed [WEIGHT_W-1:0] acc_ff, acc_in;
   logic [DOF_W-1:0]         dof0_ff, dof0_in;
   logic [DOF_W-1:0]         dof1_ff, dof1_in;
   logic [DOF_W-1:0]         dof2_ff, dof2_in;
   logic                     rd_inr_ff, rd_inr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ENTRY_W-1:0] rsp_value_ff, rsp_value_in;
   logic [DOF_W-1:0]         rsp_addr_ff, rsp_addr_in;

   logic                     req_accept;
   action_type               action;
   logic [CMP_W-1:0]         req_ext;
   logic                     req_inr;
   logic [DOF_W-1:0]         idx_sel;
   logic [CMP_W-1:0]         idx_ext;
   logic                     idx_inr;
   logic [CW-1:0]            pcount;
   logic [CW-1:0]            nx, ny, nz;
   logic                     carry_x, carry_y, carry_z;
   logic                     slot_ok;
   logic                     last_idx;

   logic                     wt_wr_en;
   logic                     wt_rd_en;
   logic [AXIS_W-1:0]        wt_rd_axis;
   logic [PW-1:0]            wt_rd_pos;
   logic signed [WEIGHT_W-1:0] wt_q;

   logic signed [WEIGHT_W-1:0] mul_a, mul_b, mul_p;

   logic                     dg_wr_en;
   logic [DAW-1:0]           dg_wr_addr;
   logic [ENTRY_W-1:0]       dg_wr_data;
   logic                     dg_rd_en;
   logic [DAW-1:0]           dg_rd_addr;
   logic signed [ENTRY_W-1:0] dg_q;
   logic signed [ENTRY_W:0]  sum_ext;
   logic signed [ENTRY_W-1:0] sum_sat;

   assign req_stall  = clr_ff || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign action     = action_type'(req_action);

   assign req_ext = CMP_W'(req_dof_first);
   assign req_inr = req_ext < CMP_W'(DIAG_DEPTH);

   always_comb begin
      unique case (k_ff)
         2'd0:    idx_sel = dof0_ff;
         2'd1:    idx_sel = dof1_ff;
         default: idx_sel = dof2_ff;
      endcase
   end
   assign idx_ext = CMP_W'(idx_sel);
   assign idx_inr = idx_ext < CMP_W'(DIAG_DEPTH);

   assign slot_ok = (SCW'(req_point_slot) < SCW'(MAX_POINTS)) && (req_axis <= AXIS_Z);

   // clamp the configured point count into the supported range
   always_comb begin
      pcount = CW'(ppa_ff);
      if (pcount < CW'(MIN_POINTS)) begin
         pcount = CW'(MIN_POINTS);
      end else if (pcount > CW'(MAX_POINTS)) begin
         pcount = CW'(MAX_POINTS);
      end
   end

   assign nx      = CW'(pos_x_ff) + CW'(1);
   assign ny      = CW'(pos_y_ff) + CW'(1);
   assign nz      = CW'(pos_z_ff) + CW'(1);
   assign carry_x = nx >= pcount;
   assign carry_y = ny >= pcount;
   assign carry_z = nz >= pcount;
   assign last_idx = (k_ff == 2'd2) || ((k_ff == 2'd0) && !vec_ff);

   // weight port
   assign wt_wr_en = req_accept && (action == ACT_LOAD_WEIGHT) && slot_ok;

   always_comb begin
      wt_rd_en   = 1'b0;
      wt_rd_axis = AXIS_X;
      wt_rd_pos  = pos_x_ff;
      unique case (state_ff)
         ST_MUL_CJ: begin
            wt_rd_en   = 1'b1;
            wt_rd_axis = AXIS_X;
            wt_rd_pos  = pos_x_ff;
         end
         ST_MUL_X: begin
            wt_rd_en   = 1'b1;
            wt_rd_axis = AXIS_Y;
            wt_rd_pos  = pos_y_ff;
         end
         ST_MUL_Y: begin
            wt_rd_en   = 1'b1;
            wt_rd_axis = AXIS_Z;
            wt_rd_pos  = pos_z_ff;
         end
         default: begin
         end
      endcase
   end

   sdsa_wtab #(
      .POS_W (PW)
   ) u_wtab (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wt_wr_en),
      .wr_axis (req_axis),
      .wr_pos  (PW'(req_point_slot)),
      .wr_data (req_weight_value),
      .rd_en   (wt_rd_en),
      .rd_axis (wt_rd_axis),
      .rd_pos  (wt_rd_pos),
      .rd_data (wt_q)
   );

   // shared multiplier operands
   assign mul_a = (state_ff == ST_MUL_CJ) ? coef_ff : acc_ff;
   assign mul_b = (state_ff == ST_MUL_CJ) ? jac_ff : wt_q;

   sdsa_qmul u_qmul (
      .a (mul_a),
      .b (mul_b),
      .p (mul_p)
   );

   // saturating add of the point value to the entry
   assign sum_ext = {dg_q[ENTRY_W-1], dg_q}
                  + {{(ENTRY_W + 1 - WEIGHT_W){acc_ff[WEIGHT_W-1]}}, acc_ff};
   always_comb begin
      if (sum_ext[ENTRY_W] == sum_ext[ENTRY_W-1]) begin
         sum_sat = sum_ext[ENTRY_W-1:0];
      end else if (sum_ext[ENTRY_W]) begin
         sum_sat = {1'b1, {(ENTRY_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(ENTRY_W-1){1'b1}}};
      end
   end

   // diagonal RAM ports
   always_comb begin
      dg_wr_en   = 1'b0;
      dg_wr_addr = req_ext[DAW-1:0];
      dg_wr_data = req_entry_value;
      dg_rd_en   = 1'b0;
      dg_rd_addr = req_ext[DAW-1:0];
      if (clr_ff) begin
         dg_wr_en   = 1'b1;
         dg_wr_addr = clr_addr_ff;
         dg_wr_data = '0;
      end else if (state_ff == ST_RMW_WR) begin
         dg_wr_en   = idx_inr;
         dg_wr_addr = idx_ext[DAW-1:0];
         dg_wr_data = sum_sat;
      end else if (req_accept && (action == ACT_WRITE_ENTRY)) begin
         dg_wr_en = req_inr;
      end
      if (state_ff == ST_RMW_RD) begin
         dg_rd_en   = idx_inr;
         dg_rd_addr = idx_ext[DAW-1:0];
      end else if (req_accept && (action == ACT_READ_ENTRY)) begin
         dg_rd_en = req_inr;
      end
   end

   sdsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DIAG_DEPTH)
   ) u_diag (
      .clock   (clock),
      .wr_en   (dg_wr_en),
      .wr_addr (dg_wr_addr),
      .wr_data (dg_wr_data),
      .rd_en   (dg_rd_en),
      .rd_addr (dg_rd_addr),
      .rd_data (dg_q)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      ppa_in       = ppa_ff;
      vec_in       = vec_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      k_in         = k_ff;
      coef_in      = coef_ff;
      jac_in       = jac_ff;
      acc_in       = acc_ff;
      dof0_in      = dof0_ff;
      dof1_in      = dof1_ff;
      dof2_in      = dof2_ff;
      rd_inr_in    = rd_inr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_addr_in  = rsp_addr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + DAW'(1);
         if (clr_addr_ff == DAW'(DIAG_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end

      if (csr_we) begin
         if (csr_index == CSR_POINTS_PER_AXIS) begin
            ppa_in = csr_wdata[PPA_W-1:0];
         end else if (csr_index == CSR_VECTOR_MODE) begin
            vec_in = csr_wdata[0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               coef_in   = req_coefficient;
               jac_in    = req_jacobian_det;
               dof0_in   = req_dof_first;
               dof1_in   = req_dof_second;
               dof2_in   = req_dof_third;
               rd_inr_in = req_inr;
               k_in      = 2'd0;
               unique case (action)
                  ACT_LOAD_WEIGHT: begin
                     pos_x_in = '0;
                     pos_y_in = '0;
                     pos_z_in = '0;
                  end
                  ACT_WRITE_ENTRY: begin
                  end
                  ACT_ACCUMULATE: begin
                     state_in = ST_MUL_CJ;
                  end
                  ACT_READ_ENTRY: begin
                     state_in = ST_READ_RSP;
                  end
               endcase
            end
         end
         ST_MUL_CJ: begin
            acc_in   = mul_p;
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            acc_in   = mul_p;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            acc_in   = mul_p;
            state_in = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            acc_in   = mul_p;
            state_in = ST_RMW_RD;
         end
         ST_RMW_RD: begin
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            if (last_idx) begin
               // advance the point counters, x fastest
               pos_x_in = carry_x ? '0 : nx[PW-1:0];
               if (carry_x) begin
                  pos_y_in = carry_y ? '0 : ny[PW-1:0];
                  if (carry_y) begin
                     pos_z_in = carry_z ? '0 : nz[PW-1:0];
                  end
               end
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_RMW_RD;
            end
         end
         ST_READ_RSP: begin
            // hold the RAM data until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_inr_ff ? dg_q : '0;
               rsp_addr_in  = dof0_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         ppa_ff       <= PPA_RESET;
         vec_ff       <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_z_ff     <= '0;
         k_ff         <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         ppa_ff       <= ppa_in;
         vec_ff       <= vec_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
         jac_ff       <= jac_in;
         acc_ff       <= acc_in;
         dof0_ff      <= dof0_in;
         dof1_ff      <= dof1_in;
         dof2_ff      <= dof2_in;
         rd_inr_ff    <= rd_inr_in;
         rsp_value_ff <= rsp_value_in;
         rsp_addr_ff  <= rsp_addr_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_read_address = rsp_addr_ff;

endmodule
`default_nettype wire

@@ sv/sdsa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module sdsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/sdsa_wtab.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsa_wtab
// Quadrature weight tables for the x, y and z axes in one RAM, with a valid
// bit per entry so that an entry never loaded reads as zero.
// ----------------------------------------------------------------------------
module sdsa_wtab #(
   parameter int POS_W = 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [sdsa_pkg::AXIS_W-1:0]  wr_axis,
   input  wire logic [POS_W-1:0]             wr_pos,
   input  wire logic [sdsa_pkg::WEIGHT_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [sdsa_pkg::AXIS_W-1:0]  rd_axis,
   input  wire logic [POS_W-1:0]             rd_pos,
   output logic      [sdsa_pkg::WEIGHT_W-1:0] rd_data
);

   import sdsa_pkg::*;

   localparam int DEPTH = 3 * (1 << POS_W);
   localparam int AW    = POS_W + AXIS_W;

   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   logic [DEPTH-1:0]    valid_ff;
   logic [DEPTH-1:0]    valid_in;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic [WEIGHT_W-1:0] ram_q;

   assign wr_addr = {wr_axis, wr_pos};
   assign rd_addr = {rd_axis, rd_pos};

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   sdsa_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_data = rd_valid_ff ? ram_q : '0;

endmodule
`default_nettype wire

@@ sv/sdsa_qmul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdsa_qmul
// Shared Q8.24 multiplier: full product, floor shift by the fraction width,
// saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module sdsa_qmul (
   input  wire logic signed [sdsa_pkg::WEIGHT_W-1:0] a,
   input  wire logic signed [sdsa_pkg::WEIGHT_W-1:0] b,
   output logic      signed [sdsa_pkg::WEIGHT_W-1:0] p
);

   import sdsa_pkg::*;

   localparam int PW = 2 * WEIGHT_W;

   logic signed [PW-1:0]         prod;
   logic signed [PW-1:0]         shifted;
   logic        [PW-WEIGHT_W:0]  upper;

   assign prod    = a * b;
   // arithmetic shift rounds toward minus infinity
   assign shifted = prod >>> FRAC_W;
   assign upper   = shifted[PW-1:WEIGHT_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         p = shifted[WEIGHT_W-1:0];
      end else if (prod[PW-1]) begin
         p = {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else begin
         p = {1'b0, {(WEIGHT_W-1){1'b1}}};
      end
   end

endmodule
`default_nettype wire
